// ----- rtl/otsu_threshold_select_core_defines.svh -----
// Assertion macros shared by the threshold select RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef OTSU_THRESHOLD_SELECT_CORE_DEFINES_SVH
`define OTSU_THRESHOLD_SELECT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define OTSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("otsu check failed");
`define OTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("otsu check failed");
`else
`define OTSU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/otsu_pkg.sv -----
// Shared types for the threshold select block: scan states and back-end status.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package otsu_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_ACC,
		S_M1GO,
		S_M1,
		S_SUB,
		S_M2GO,
		S_M2,
		S_M3GO,
		S_M3,
		S_CMP,
		S_DONE
	} otsu_state_t;

	typedef struct packed {
		logic pop;
		logic done;
	} otsu_back_stat_t;

endpackage
`default_nettype wire

// ----- rtl/otsu_mul.sv -----
// Bit-serial shift-add multiplier: one bit of b per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module otsu_mul #(
	parameter int AW = 8,
	parameter int BW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic                  busy,
	output logic [AW+BW-1:0]      p
);
	localparam int CNTW = $clog2(BW + 1);

	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] p_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic [AW:0]      add;

	always_comb begin
		add = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(BW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {add, p_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign p    = p_q;
endmodule
`default_nettype wire

// ----- rtl/otsu_front.sv -----
// Load side: takes bins, writes the bin memory, sums count and weighted count.
// Depends on nothing; hands a finished histogram to the job queue.
`timescale 1ns / 1ps
`default_nettype none
module otsu_front #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   accept,
	input  wire logic [COUNT_BITS-1:0]                  bin_count,
	input  wire logic                                   last_bin,
	output logic                                        wr_en,
	output logic                                        wr_bank,
	output logic [$clog2(BINS)-1:0]                     wr_addr,
	output logic [COUNT_BITS-1:0]                       wr_data,
	output logic                                        push,
	output logic                                        job_bank,
	output logic [$clog2(BINS+1)-1:0]                   job_n,
	output logic [COUNT_BITS+$clog2(BINS)-1:0]          job_total,
	output logic [COUNT_BITS+2*$clog2(BINS)-1:0]        job_wsum
);
	localparam int LW = $clog2(BINS);
	localparam int NW = $clog2(BINS + 1);
	localparam int TW = COUNT_BITS + LW;
	localparam int WW = TW + LW;

	logic [NW-1:0] load_q;
	logic [TW-1:0] total_q;
	logic [WW-1:0] wsum_q;
	logic          bank_q;
	logic          in_range;
	logic [TW-1:0] prod;
	logic [TW-1:0] tot_n;
	logic [WW-1:0] ws_n;

	always_comb begin
		in_range = load_q < NW'(BINS);
		prod     = TW'(load_q[LW-1:0]) * TW'(bin_count);
		tot_n    = total_q + (in_range ? TW'(bin_count) : '0);
		ws_n     = wsum_q + (in_range ? WW'(prod) : '0);
	end

	// drop bins past the end, but still let the flag close the histogram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= '0;
			total_q <= '0;
			wsum_q  <= '0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (last_bin) begin
				load_q  <= '0;
				total_q <= '0;
				wsum_q  <= '0;
				bank_q  <= ~bank_q;
			end else begin
				load_q  <= load_q + NW'(in_range);
				total_q <= tot_n;
				wsum_q  <= ws_n;
			end
		end
	end

	assign wr_en     = accept & in_range;
	assign wr_bank   = bank_q;
	assign wr_addr   = load_q[LW-1:0];
	assign wr_data   = bin_count;
	assign push      = accept & last_bin;
	assign job_bank  = bank_q;
	assign job_n     = load_q + NW'(in_range);
	assign job_total = tot_n;
	assign job_wsum  = ws_n;
endmodule
`default_nettype wire

// ----- rtl/otsu_jobq.sv -----
// Two-entry job queue between the load side and the scan side.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module otsu_jobq #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      dout
);
	logic [W-1:0] ent_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= din;
	end

	assign empty = cnt_q == 2'd0;
	assign dout  = ent_q[rd_q];
endmodule
`default_nettype wire

// ----- rtl/otsu_back.sv -----
// Scan side: holds the two-bank bin memory and walks the levels, comparing
// between-class variances exactly as fractions. Depends on otsu_pkg, otsu_mul.
`timescale 1ns / 1ps
`default_nettype none
module otsu_back #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   wr_en,
	input  wire logic                                   wr_bank,
	input  wire logic [$clog2(BINS)-1:0]                wr_addr,
	input  wire logic [COUNT_BITS-1:0]                  wr_data,
	input  wire logic                                   job_valid,
	input  wire logic                                   job_bank,
	input  wire logic [$clog2(BINS+1)-1:0]              job_n,
	input  wire logic [COUNT_BITS+$clog2(BINS)-1:0]     job_total,
	input  wire logic [COUNT_BITS+2*$clog2(BINS)-1:0]   job_wsum,
	output otsu_pkg::otsu_back_stat_t                   stat,
	output logic                                        threshold_valid,
	output logic [7:0]                                  threshold
);
	import otsu_pkg::*;

	localparam int LW  = $clog2(BINS);
	localparam int NW  = $clog2(BINS + 1);
	localparam int TW  = COUNT_BITS + LW;
	localparam int WW  = TW + LW;
	localparam int PW  = TW + WW;
	localparam int SW  = 2 * PW;
	localparam int DNW = 2 * TW;
	localparam int CW  = SW + DNW;

	logic [COUNT_BITS-1:0] mem [2][BINS];
	logic [COUNT_BITS-1:0] rdata_q;
	logic                  rd_en;

	otsu_state_t   state_q, state_d;
	logic          bank_q;
	logic [NW-1:0] n_q, idx_q;
	logic [TW-1:0] total_q, wb_q, wf_q, prod_q, wbn;
	logic [WW-1:0] wsum_q, sumb_q;
	logic [PW-1:0] d_q;
	logic [SW-1:0] best_num_q;
	logic [DNW-1:0] best_den_q;
	logic [LW-1:0] level_q;
	logic          go1, go2, go3;

	logic          pa_busy, pb_busy, den_busy, sq_busy, lhs_busy, rhs_busy;
	logic [PW-1:0] pa, pb;
	logic [DNW-1:0] den;
	logic [SW-1:0] sq;
	logic [CW-1:0] lhs, rhs;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_bank][wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[bank_q][idx_q[LW-1:0]];
	end

	otsu_mul #(.AW(WW), .BW(TW)) u_pa (
		.clk(clk), .arst_n(arst_n), .start(go1), .a(sumb_q), .b(total_q),
		.busy(pa_busy), .p(pa)
	);
	otsu_mul #(.AW(WW), .BW(TW)) u_pb (
		.clk(clk), .arst_n(arst_n), .start(go1), .a(wsum_q), .b(wb_q),
		.busy(pb_busy), .p(pb)
	);
	otsu_mul #(.AW(TW), .BW(TW)) u_den (
		.clk(clk), .arst_n(arst_n), .start(go1), .a(wb_q), .b(wf_q),
		.busy(den_busy), .p(den)
	);
	otsu_mul #(.AW(PW), .BW(PW)) u_sq (
		.clk(clk), .arst_n(arst_n), .start(go2), .a(d_q), .b(d_q),
		.busy(sq_busy), .p(sq)
	);
	otsu_mul #(.AW(SW), .BW(DNW)) u_lhs (
		.clk(clk), .arst_n(arst_n), .start(go3), .a(sq), .b(best_den_q),
		.busy(lhs_busy), .p(lhs)
	);
	otsu_mul #(.AW(SW), .BW(DNW)) u_rhs (
		.clk(clk), .arst_n(arst_n), .start(go3), .a(best_num_q), .b(den),
		.busy(rhs_busy), .p(rhs)
	);

	assign wbn = wb_q + TW'(rdata_q);

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		go1       = 1'b0;
		go2       = 1'b0;
		go3       = 1'b0;
		stat.pop  = 1'b0;
		stat.done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					stat.pop = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				if (idx_q == n_q) begin
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				// skip an empty lower class, stop on an empty upper class
				if (wbn == '0)
					state_d = S_READ;
				else if (wbn >= total_q)
					state_d = S_DONE;
				else
					state_d = S_ACC;
			end
			S_ACC:  state_d = S_M1GO;
			S_M1GO: begin
				go1     = 1'b1;
				state_d = S_M1;
			end
			S_M1: begin
				if (!pa_busy && !pb_busy && !den_busy)
					state_d = S_SUB;
			end
			S_SUB:  state_d = S_M2GO;
			S_M2GO: begin
				go2     = 1'b1;
				state_d = S_M2;
			end
			S_M2: begin
				if (!sq_busy)
					state_d = S_M3GO;
			end
			S_M3GO: begin
				go3     = 1'b1;
				state_d = S_M3;
			end
			S_M3: begin
				if (!lhs_busy && !rhs_busy)
					state_d = S_CMP;
			end
			S_CMP:  state_d = S_READ;
			S_DONE: begin
				stat.done = 1'b1;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				bank_q     <= job_bank;
				n_q        <= job_n;
				total_q    <= job_total;
				wsum_q     <= job_wsum;
				idx_q      <= '0;
				wb_q       <= '0;
				sumb_q     <= '0;
				best_num_q <= '0;
				best_den_q <= DNW'(1);
				level_q    <= '0;
			end
			S_LOAD: begin
				wb_q   <= wbn;
				prod_q <= TW'(idx_q[LW-1:0]) * TW'(rdata_q);
				if (wbn == '0)
					idx_q <= idx_q + NW'(1);
			end
			S_ACC: begin
				sumb_q <= sumb_q + WW'(prod_q);
				wf_q   <= total_q - wb_q;
			end
			S_SUB: begin
				d_q <= (pa >= pb) ? pa - pb : pb - pa;
			end
			S_CMP: begin
				if (lhs > rhs) begin
					best_num_q <= sq;
					best_den_q <= den;
					level_q    <= idx_q[LW-1:0];
				end
				idx_q <= idx_q + NW'(1);
			end
			default: begin
			end
		endcase
	end

	assign threshold_valid = state_q == S_DONE;
	assign threshold       = 8'(level_q);
endmodule
`default_nettype wire

// ----- rtl/otsu_threshold_select_core.sv -----
// Otsu threshold select, top level: load side, job queue and scan side.
// Depends on otsu_pkg, otsu_front, otsu_jobq, otsu_back and the defines header.
//
//   channel   handshake                 payload
//   input     start && !busy            bin_count, last_bin
//   result    threshold_valid (1 cyc)   threshold
//
// A bin is taken whenever start is high and busy is low. After the flagged bin
// the scan reads each loaded level and runs the bit-serial multipliers in
// three rounds before its compare; a level with an empty lower class skips
// them. The scan stops at an empty upper class and then flags the result.
// Two histograms may be outstanding: while one scans the next loads into the
// other memory bank. busy rises when both banks are taken.
// Reset clears control only; the bin memory is never cleared. The receiver
// cannot stall: the result shows for one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "otsu_threshold_select_core_defines.svh"
module otsu_threshold_select_core #(
	parameter int BINS       = 256,
	parameter int COUNT_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [COUNT_BITS-1:0] bin_count,
	input  wire logic                  last_bin,
	output logic                       threshold_valid,
	output logic [7:0]                 threshold
);
	import otsu_pkg::*;

	localparam int LW = $clog2(BINS);
	localparam int NW = $clog2(BINS + 1);
	localparam int TW = COUNT_BITS + LW;
	localparam int WW = TW + LW;
	localparam int JW = 1 + NW + TW + WW;

	logic                  accept;
	logic                  wr_en, wr_bank;
	logic [LW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  push;
	logic                  f_bank, q_bank;
	logic [NW-1:0]         f_n, q_n;
	logic [TW-1:0]         f_total, q_total;
	logic [WW-1:0]         f_wsum, q_wsum;
	logic                  q_empty;
	otsu_back_stat_t       stat;
	logic [1:0]            jobs_q;

	assign accept = start & ~busy;
	assign busy   = jobs_q == 2'd2;

	otsu_front #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept),
		.bin_count(bin_count), .last_bin(last_bin),
		.wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
		.push(push), .job_bank(f_bank), .job_n(f_n),
		.job_total(f_total), .job_wsum(f_wsum)
	);

	otsu_jobq #(.W(JW)) u_jobq (
		.clk(clk), .arst_n(arst_n), .push(push),
		.din({f_bank, f_n, f_total, f_wsum}),
		.pop(stat.pop), .empty(q_empty),
		.dout({q_bank, q_n, q_total, q_wsum})
	);

	otsu_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
		.job_valid(~q_empty), .job_bank(q_bank), .job_n(q_n),
		.job_total(q_total), .job_wsum(q_wsum),
		.stat(stat), .threshold_valid(threshold_valid), .threshold(threshold)
	);

	// count histograms that are queued or scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			jobs_q <= '0;
		else
			jobs_q <= jobs_q + 2'(push) - 2'(stat.done);
	end

	`OTSU_ASSERT_SAME(a_jobs_bound, clk, arst_n, 1'b1, jobs_q != 2'd3)
	`OTSU_ASSERT_SAME(a_done_has_job, clk, arst_n, stat.done, jobs_q != 2'd0)
	`OTSU_ASSERT_SAME(a_pop_has_entry, clk, arst_n, stat.pop, !q_empty)
	`OTSU_ASSERT_NEXT(a_push_counts, clk, arst_n, push && !stat.done && jobs_q == 2'd0,
		jobs_q == 2'd1)
endmodule
`default_nettype wire

// ----- dv/otsu_threshold_select_core_tb.sv -----
// Testbench for otsu_threshold_select_core: streams histograms bin by bin and checks each
// threshold against an exact-rational predictor held in a small scoreboard class.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

module otsu_threshold_select_core_tb;

	localparam int NUM_BINS    = 256;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEM_TARGET = 650;

	class otsu_scoreboard;
		bit [23:0]         hist_bins[$];
		longint unsigned   pixel_sum;
		longint unsigned   level_sum;
		bit [7:0]          thresholds_due[$];
		int                errors;

		function new();
			pixel_sum = 0;
			level_sum = 0;
			errors    = 0;
		endfunction

		// exact compare of d^2/(wB*wF) by cross-multiplication, 320-bit wrap
		function bit [7:0] select_threshold();
			logic [319:0]    best_num, best_den, num, den, pa, pb, d, lhs, rhs;
			longint unsigned wb, wf, sumb;
			int              level;
			best_num = 0;
			best_den = 1;
			wb       = 0;
			sumb     = 0;
			level    = 0;
			for (int i = 0; i < hist_bins.size(); i++) begin
				wb += hist_bins[i];
				if (wb == 0)
					continue;
				if (wb >= pixel_sum)
					break;
				wf   = pixel_sum - wb;
				sumb += 64'(i) * hist_bins[i];
				pa   = sumb * pixel_sum;
				pb   = level_sum * wb;
				d    = (pa >= pb) ? pa - pb : pb - pa;
				num  = d * d;
				den  = wb * wf;
				lhs  = num * best_den;
				rhs  = best_num * den;
				if (lhs > rhs) begin
					best_num = num;
					best_den = den;
					level    = i;
				end
			end
			return level[7:0];
		endfunction

		function void note_bin(bit [23:0] count, bit last);
			if (hist_bins.size() < NUM_BINS) begin
				level_sum += 64'(hist_bins.size()) * count;
				pixel_sum += count;
				hist_bins.push_back(count);
			end
			if (last) begin
				thresholds_due.push_back(select_threshold());
				hist_bins.delete();
				pixel_sum = 0;
				level_sum = 0;
			end
		endfunction

		function void check_result(bit [7:0] got);
			bit [7:0] want;
			if (thresholds_due.size() == 0) begin
				if (errors < 10)
					$display("unexpected threshold %0d", got);
				errors++;
				return;
			end
			want = thresholds_due.pop_front();
			if (got !== want) begin
				if (errors < 10)
					$display("threshold mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [23:0] bin_count;
	logic        last_bin;
	logic        threshold_valid;
	logic [7:0]  threshold;

	otsu_threshold_select_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.bin_count       (bin_count),
		.last_bin        (last_bin),
		.threshold_valid (threshold_valid),
		.threshold       (threshold)
	);

	otsu_scoreboard sb = new();
	int             items_sent = 0;
	int             cycle_count = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("otsu_threshold_select_core test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && threshold_valid)
			sb.check_result(threshold);
	end

	// hold the item until an edge sees start high and busy low
	task automatic send_bin(bit [23:0] count, bit last);
		start     <= 1'b1;
		bin_count <= count;
		last_bin  <= last;
		do
			@(posedge clk);
		while (busy);
		sb.note_bin(count, last);
		items_sent++;
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			start    <= 1'b0;
			last_bin <= $urandom_range(0, 1);
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic bit [23:0] random_count(bit peaked);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 24'd0;
		if (r < 15)
			return 24'hFFFFFF;
		if (r < 55 && !peaked)
			return $urandom_range(0, 15);
		return $urandom();
	endfunction

	task automatic send_hist(bit [23:0] counts[$], bit use_gaps);
		for (int i = 0; i < counts.size(); i++) begin
			send_bin(counts[i], i == counts.size() - 1);
			if (use_gaps)
				idle_cycles(random_gap());
		end
	endtask

	task automatic send_random_hist(int len, bit use_gaps);
		bit [23:0] counts[$];
		int        peak_a, peak_b;
		peak_a = $urandom_range(0, len - 1);
		peak_b = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++)
			counts.push_back(random_count(i == peak_a || i == peak_b));
		send_hist(counts, use_gaps);
	endtask

	initial begin
		bit [23:0] h[$];
		bit        calm;
		arst_n    = 1'b0;
		start     = 1'b0;
		bin_count = 24'd0;
		last_bin  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty, single bin, flat, two-level, leading and trailing zeros
		h = '{24'd0};                                send_hist(h, 0);
		h = '{24'hFFFFFF};                           send_hist(h, 0);
		h = '{24'hFFFFFF, 24'hFFFFFF};               send_hist(h, 1);
		h = '{24'd1, 24'd0};                         send_hist(h, 0);
		h = '{24'd0, 24'd0, 24'd7, 24'd3};           send_hist(h, 1);
		h = '{24'd5, 24'd5, 24'd5, 24'd5};           send_hist(h, 0);
		h = '{24'd9, 24'd1, 24'd0, 24'd1, 24'd9};    send_hist(h, 1);
		h = '{24'h800000, 24'd0, 24'h7FFFFF, 24'd0, 24'd0}; send_hist(h, 0);
		h = '{24'hAAAAAA, 24'h555555};               send_hist(h, 1);

		// drain fully before continuing
		idle_cycles(1);
		wait (sb.thresholds_due.size() == 0);
		@(posedge clk);

		// one overlong histogram: extra bins dropped, flag still ends it
		send_random_hist(NUM_BINS + 3, 0);

		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			send_random_hist($urandom_range(1, 12), !calm);
			if (!calm)
				idle_cycles(random_gap());
		end
		idle_cycles(1);

		wait (sb.thresholds_due.size() == 0);
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.thresholds_due.size() == 0) begin
			$display("otsu_threshold_select_core test passed");
		end else begin
			$display("otsu_threshold_select_core test failed");
		end
		$finish;
	end

endmodule

// ----- otsu_threshold_select_core.f -----
+incdir+rtl
rtl/otsu_pkg.sv
rtl/otsu_mul.sv
rtl/otsu_front.sv
rtl/otsu_jobq.sv
rtl/otsu_back.sv
rtl/otsu_threshold_select_core.sv
dv/otsu_threshold_select_core_tb.sv
